// ===== rtl/xyz_to_srgb_minmax_stretch_top_macros.svh =====
// Assertion macros for the checker file.
`ifndef XYZ_TO_SRGB_MINMAX_STRETCH_TOP_MACROS_SVH
`define XYZ_TO_SRGB_MINMAX_STRETCH_TOP_MACROS_SVH

// Check that the consequent holds in the cycle after the antecedent.
`define XSRGB_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("xsrgb check failed");

// Check that the consequent holds in the same cycle as the antecedent.
`define XSRGB_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("xsrgb check failed");

`endif

// ===== rtl/xsrgb_pkg.sv =====
package xsrgb_pkg;

    localparam int FRAME_PIXELS        = 4096;
    localparam int GAMMA_TABLE_ENTRIES = 1024;

    localparam int ADDR_W  = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
    localparam int IDX_W   = 12;
    localparam int XYZ_W   = 16;
    localparam int VAL_W   = 20;
    localparam int LVL_W   = 8;
    localparam int PIX_W   = 3 * VAL_W;

    // Curve domain: Q4.16 up to 8.0 covers 2^19 codes
    localparam int DOMAIN_BITS = 19;
    localparam int LOG2E       = $clog2(GAMMA_TABLE_ENTRIES);
    localparam int SEG_SH      = DOMAIN_BITS - LOG2E;
    localparam int SEG_T1      = (1 << DOMAIN_BITS) / GAMMA_TABLE_ENTRIES;
    localparam int CRV_AW      = LOG2E + 1;
    localparam int DPROD_W     = VAL_W + 1 + SEG_SH + 1;

    localparam int  LIN_THRESHOLD = 205;
    localparam int  LIN_SLOPE     = 846725;
    localparam int  CURVE_GAIN    = 69140;
    localparam int  CURVE_OFFSET  = 3604;
    localparam longint LIN205     = (longint'(LIN_THRESHOLD) * LIN_SLOPE + 32768) >>> 16;

    // Doubled span of the first curve segment and its half
    localparam longint SEG_DEN  = 2 * (longint'(SEG_T1) - LIN_THRESHOLD);
    localparam longint SEG_HALF = SEG_DEN >>> 1;

    // Opcodes carried in tuser
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef logic signed [VAL_W-1:0] val_t;
    typedef logic signed [18:0]      coef_t;
    typedef val_t curve_tab_t [0:GAMMA_TABLE_ENTRIES];
    typedef val_t seg_tab_t   [0:SEG_T1-1];

    localparam val_t VAL_MAX = 20'sh7FFFF;
    localparam val_t VAL_MIN = 20'sh80000;

    localparam logic signed [DPROD_W-1:0] DPROD_HALF = DPROD_W'(1) << (SEG_SH - 1);

    // sRGB D65 matrix in Q.16, row per output channel
    localparam coef_t COEF [0:2][0:2] = '{
        '{ 19'sd212366, -19'sd100738, -19'sd32672 },
        '{ -19'sd63522,  19'sd122946,  19'sd2723  },
        '{ 19'sd3647,   -19'sd13371,   19'sd69286 }
    };

    function automatic val_t sat20(input logic signed [47:0] v);
        if (v > 48'sd524287)
            return VAL_MAX;
        if (v < -48'sd524288)
            return VAL_MIN;
        return v[VAL_W-1:0];
    endfunction

    function automatic longint unsigned isqrt(input longint unsigned x);
        longint unsigned r;
        longint unsigned c;
        r = 0;
        for (int i = 31; i >= 0; i--)
        begin
            c = r | (64'd1 << i);
            if (c * c <= x)
                r = c;
        end
        return r;
    endfunction

    function automatic longint unsigned icbrt(input longint unsigned x);
        longint unsigned r;
        longint unsigned c;
        r = 0;
        for (int i = 20; i >= 0; i--)
        begin
            c = r | (64'd1 << i);
            if (c * c * c <= x)
                r = c;
        end
        return r;
    endfunction

    // Floor quotient by long division, for table building
    function automatic longint unsigned udiv(input longint unsigned n,
                                             input longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        q = 0;
        r = 0;
        for (int i = 63; i >= 0; i--)
        begin
            r = (r << 1) | ((n >> i) & 64'd1);
            if (r >= d)
            begin
                r = r - d;
                q = q | (64'd1 << i);
            end
        end
        return q;
    endfunction

    // 1.055 * t^(1/2.4) - 0.055 in Q.16 from integer roots
    function automatic val_t curve_point(input longint unsigned t);
        longint unsigned a;
        longint unsigned b;
        longint unsigned p;
        longint          g;
        a = isqrt(isqrt(t << 16) << 16);
        b = isqrt(icbrt(t << 32) << 16);
        p = (a * b + 64'd32768) >> 16;
        g = longint'((p * CURVE_GAIN + 64'd32768) >> 16) - CURVE_OFFSET;
        return g[VAL_W-1:0];
    endfunction

    function automatic curve_tab_t build_curve();
        curve_tab_t tab;
        longint unsigned t;
        for (int k = 0; k <= GAMMA_TABLE_ENTRIES; k++)
        begin
            t = 64'(k) << SEG_SH;
            tab[k] = curve_point(t);
        end
        return tab;
    endfunction

    // First curve segment: straight line from the linear knee to the first point
    function automatic seg_tab_t build_seg();
        seg_tab_t s;
        longint e1;
        longint num;
        longint q;
        e1  = longint'(curve_point(64'(SEG_T1)));
        for (int i = 0; i < SEG_T1; i++)
        begin
            if (i <= LIN_THRESHOLD)
                s[i] = '0;
            else
            begin
                num = 2 * (longint'(i) - LIN_THRESHOLD) * (e1 - LIN205);
                q   = num + SEG_HALF;
                q   = (q >= 0) ? longint'(udiv(q, SEG_DEN))
                               : -longint'(udiv(-q + SEG_DEN - 1, SEG_DEN));
                s[i] = sat20(48'(LIN205 + q));
            end
        end
        return s;
    endfunction

    localparam curve_tab_t CURVE_TAB = build_curve();
    localparam seg_tab_t   SEG_TAB   = build_seg();

endpackage

// ===== rtl/xyz_to_srgb_minmax_stretch_top.sv =====
// Channel  | Dir | Signals                              | Payload
// s_axis   | in  | s_axis_tvalid/tready/tdata/tuser     | index, X, Y, Z; op, frame start
// m_axis   | out | m_axis_tvalid/tready/tdata           | red, green, blue levels
//
// One item is in work at a time. A load with an in-range index runs, per channel, three
// multiply-accumulate steps, then saturation, a gamma table read, an interpolation multiply
// and a final select; then the bounds update and the frame store write (skipped out of range).
// A read runs the radix-2 restoring divider, 10 steps for each channel with an in-range index,
// a nonzero range and a value above its minimum, and waits while the output is stalled. rst_n
// clears the control state and sets the bounds to empty; the frame store is
// not cleared. A stalled output holds its register while the next item is accepted.
module xyz_to_srgb_minmax_stretch_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // pixel_index[11:0], x_value[27:12], y_value[43:28],
                                        // z_value[59:44], zero[63:60]
    input  logic [1:0]  s_axis_tuser,   // op[0], frame_start[1]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // red_level[7:0], green_level[15:8], blue_level[23:16]
);

    typedef enum logic [9:0] {
        ST_IDLE = 10'b0000000001,
        ST_MAT  = 10'b0000000010,
        ST_LIN  = 10'b0000000100,
        ST_ROM  = 10'b0000001000,
        ST_CRV  = 10'b0000010000,
        ST_FIN  = 10'b0000100000,
        ST_WR   = 10'b0001000000,
        ST_DSET = 10'b0010000000,
        ST_DIV  = 10'b0100000000,
        ST_OUT  = 10'b1000000000
    } state_t;

    localparam int AW  = xsrgb_pkg::ADDR_W;
    localparam int VW  = xsrgb_pkg::VAL_W;
    localparam int SSH = xsrgb_pkg::SEG_SH;
    localparam int DPW = xsrgb_pkg::DPROD_W;
    localparam int CAW = xsrgb_pkg::CRV_AW;

    state_t state_reg, state_next;

    logic                         idx_ok_reg, idx_ok_next;
    logic [AW-1:0]                addr_reg, addr_next;
    logic [15:0]                  xyz_reg [0:2];
    logic [15:0]                  xyz_next [0:2];
    logic [1:0]                   ch_reg, ch_next;
    logic [1:0]                   term_reg, term_next;
    logic signed [37:0]           acc_reg, acc_next;
    xsrgb_pkg::val_t              lin_reg, lin_next;
    logic signed [40:0]           lmul_reg, lmul_next;
    logic signed [DPW-1:0]        dprod_reg, dprod_next;
    xsrgb_pkg::val_t              chv_reg [0:2];
    xsrgb_pkg::val_t              chv_next [0:2];
    xsrgb_pkg::val_t              min_reg [0:2];
    xsrgb_pkg::val_t              min_next [0:2];
    xsrgb_pkg::val_t              max_reg [0:2];
    xsrgb_pkg::val_t              max_next [0:2];
    logic [30:0]                  rem_reg, rem_next;
    logic [30:0]                  dsr_reg, dsr_next;
    logic [9:0]                   quo_reg, quo_next;
    logic [3:0]                   bit_reg, bit_next;
    logic [7:0]                   lvl_reg [0:2];
    logic [7:0]                   lvl_next [0:2];
    logic                         out_valid_reg, out_valid_next;
    logic [23:0]                  out_data_reg, out_data_next;

    // Memory read data
    xsrgb_pkg::val_t              e0_reg, e1_reg, seg_reg;
    logic [xsrgb_pkg::PIX_W-1:0]  rd_data_reg;
    logic [xsrgb_pkg::PIX_W-1:0]  frame_mem [0:xsrgb_pkg::FRAME_PIXELS-1];

    // Input fields
    logic                         in_op, in_fs, in_range, accept;
    logic [11:0]                  in_idx;
    logic [31:0]                  idx_wide;
    logic [AW-1:0]                in_addr;

    // Datapath temporaries
    logic signed [35:0]           mprod;
    logic [CAW-1:0]               crv_k, crv_k1;
    logic signed [VW:0]           ediff;
    xsrgb_pkg::val_t              curve_val;
    xsrgb_pkg::val_t              sv, slo, shi;
    logic signed [VW:0]           sdd, sden;
    logic [30:0]                  trial, rem_sub;
    logic [9:0]                   quo_fin;

    assign in_idx   = s_axis_tdata[11:0];
    assign in_op    = s_axis_tuser[0];
    assign in_fs    = s_axis_tuser[1];
    assign idx_wide = 32'(in_idx);
    assign in_addr  = idx_wide[AW-1:0];
    assign in_range = idx_wide < 32'(xsrgb_pkg::FRAME_PIXELS);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign crv_k  = {1'b0, lin_reg[xsrgb_pkg::DOMAIN_BITS-1:SSH]};
    assign crv_k1 = crv_k + CAW'(1);

    // Next-state and datapath logic
    always_comb
    begin
        state_next     = state_reg;
        idx_ok_next    = idx_ok_reg;
        addr_next      = addr_reg;
        ch_next        = ch_reg;
        term_next      = term_reg;
        acc_next       = acc_reg;
        lin_next       = lin_reg;
        lmul_next      = lmul_reg;
        dprod_next     = dprod_reg;
        rem_next       = rem_reg;
        dsr_next       = dsr_reg;
        quo_next       = quo_reg;
        bit_next       = bit_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        for (int i = 0; i < 3; i++)
        begin
            xyz_next[i] = xyz_reg[i];
            chv_next[i] = chv_reg[i];
            min_next[i] = min_reg[i];
            max_next[i] = max_reg[i];
            lvl_next[i] = lvl_reg[i];
        end

        mprod     = xsrgb_pkg::COEF[ch_reg][term_reg] * $signed({1'b0, xyz_reg[term_reg]});
        ediff     = {e1_reg[VW-1], e1_reg} - {e0_reg[VW-1], e0_reg};
        curve_val = '0;
        sv        = rd_data_reg[VW*ch_reg +: VW];
        slo       = min_reg[ch_reg];
        shi       = max_reg[ch_reg];
        sdd       = {sv[VW-1], sv} - {slo[VW-1], slo};
        sden      = {shi[VW-1], shi} - {slo[VW-1], slo};
        trial     = dsr_reg << bit_reg;
        rem_sub   = rem_reg - trial;
        quo_fin   = quo_reg;
        if (rem_reg >= trial)
            quo_fin[bit_reg] = 1'b1;

        // Release the output register when taken
        if (m_axis_tvalid && m_axis_tready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    idx_ok_next = in_range;
                    addr_next   = in_addr;
                    xyz_next[0] = s_axis_tdata[27:12];
                    xyz_next[1] = s_axis_tdata[43:28];
                    xyz_next[2] = s_axis_tdata[59:44];
                    ch_next     = '0;
                    term_next   = '0;
                    if (in_op == xsrgb_pkg::OP_LOAD)
                    begin
                        if (in_fs)
                        begin
                            for (int i = 0; i < 3; i++)
                            begin
                                min_next[i] = xsrgb_pkg::VAL_MAX;
                                max_next[i] = xsrgb_pkg::VAL_MIN;
                            end
                        end
                        state_next = in_range ? ST_MAT : ST_WR;
                    end
                    else
                        state_next = ST_DSET;
                end
            end
            ST_MAT:
            begin
                // Accumulate one matrix term
                acc_next = ((term_reg == 2'd0) ? 38'sd0 : acc_reg) + 38'(mprod);
                if (term_reg == 2'd2)
                begin
                    term_next  = '0;
                    state_next = ST_LIN;
                end
                else
                    term_next = term_reg + 2'd1;
            end
            ST_LIN:
            begin
                lin_next   = xsrgb_pkg::sat20(48'((acc_reg + 38'sd32768) >>> 16));
                state_next = ST_ROM;
            end
            ST_ROM:
            begin
                lmul_next  = lin_reg * 21'sd846725;
                state_next = ST_CRV;
            end
            ST_CRV:
            begin
                dprod_next = DPW'(ediff) * DPW'($signed({1'b0, lin_reg[SSH-1:0]}));
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                // Pick the linear segment, the first curve segment or the table
                if (lin_reg <= 20'sd205)
                    curve_val = xsrgb_pkg::sat20(48'((lmul_reg + 41'sd32768) >>> 16));
                else if (crv_k == '0)
                    curve_val = seg_reg;
                else
                    curve_val = xsrgb_pkg::sat20(48'(e0_reg)
                                + 48'((dprod_reg + xsrgb_pkg::DPROD_HALF) >>> SSH));
                chv_next[ch_reg] = curve_val;
                if (ch_reg == 2'd2)
                    state_next = ST_WR;
                else
                begin
                    ch_next    = ch_reg + 2'd1;
                    state_next = ST_MAT;
                end
            end
            ST_WR:
            begin
                // Widen the running bounds
                if (idx_ok_reg)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        if (chv_reg[i] < min_reg[i])
                            min_next[i] = chv_reg[i];
                        if (chv_reg[i] > max_reg[i])
                            max_next[i] = chv_reg[i];
                    end
                end
                state_next = ST_IDLE;
            end
            ST_DSET:
            begin
                if (!idx_ok_reg || (shi <= slo) || (sdd <= 21'sd0))
                begin
                    lvl_next[ch_reg] = '0;
                    if (ch_reg == 2'd2)
                        state_next = ST_OUT;
                    else
                        ch_next = ch_reg + 2'd1;
                end
                else
                begin
                    // Numerator d*510 + range, divisor 2*range
                    rem_next   = 31'({sdd[VW-1:0], 9'd0}) - 31'({sdd[VW-1:0], 1'b0})
                                 + 31'(sden[VW-1:0]);
                    dsr_next   = 31'({sden[VW-1:0], 1'b0});
                    quo_next   = '0;
                    bit_next   = 4'd9;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // One restoring division step
                if (rem_reg >= trial)
                    rem_next = rem_sub;
                quo_next = quo_fin;
                if (bit_reg == 4'd0)
                begin
                    lvl_next[ch_reg] = (quo_fin[9:8] != 2'b00) ? 8'd255 : quo_fin[7:0];
                    if (ch_reg == 2'd2)
                        state_next = ST_OUT;
                    else
                    begin
                        ch_next    = ch_reg + 2'd1;
                        state_next = ST_DSET;
                    end
                end
                else
                    bit_next = bit_reg - 4'd1;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_data_next  = {lvl_reg[2], lvl_reg[1], lvl_reg[0]};
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and bounds
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                min_reg[i] <= xsrgb_pkg::VAL_MAX;
                max_reg[i] <= xsrgb_pkg::VAL_MIN;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < 3; i++)
            begin
                min_reg[i] <= min_next[i];
                max_reg[i] <= max_next[i];
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        idx_ok_reg   <= idx_ok_next;
        addr_reg     <= addr_next;
        ch_reg       <= ch_next;
        term_reg     <= term_next;
        acc_reg      <= acc_next;
        lin_reg      <= lin_next;
        lmul_reg     <= lmul_next;
        dprod_reg    <= dprod_next;
        rem_reg      <= rem_next;
        dsr_reg      <= dsr_next;
        quo_reg      <= quo_next;
        bit_reg      <= bit_next;
        out_data_reg <= out_data_next;
        for (int i = 0; i < 3; i++)
        begin
            xyz_reg[i] <= xyz_next[i];
            chv_reg[i] <= chv_next[i];
            lvl_reg[i] <= lvl_next[i];
        end
    end

    // Gamma tables: registered reads
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_ROM)
        begin
            e0_reg  <= xsrgb_pkg::CURVE_TAB[crv_k];
            e1_reg  <= xsrgb_pkg::CURVE_TAB[crv_k1];
            seg_reg <= xsrgb_pkg::SEG_TAB[lin_reg[SSH-1:0]];
        end
    end

    // Frame store: write on load completion, registered read on accept
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_WR) && idx_ok_reg)
            frame_mem[addr_reg] <= {chv_reg[2], chv_reg[1], chv_reg[0]};
        if (accept && (in_op == xsrgb_pkg::OP_READ) && in_range)
            rd_data_reg <= frame_mem[in_addr];
    end

endmodule

// ===== rtl/xsrgb_checker.sv =====
`include "xyz_to_srgb_minmax_stretch_top_macros.svh"

module xsrgb_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [63:0] s_axis_tdata,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    // One item in work at a time: ready drops after each accepted item
    `XSRGB_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // No result appears in the cycle right after an item is taken
    `XSRGB_ASSERT_NEXT(a_no_early_result, s_axis_tvalid && s_axis_tready, !$rose(m_axis_tvalid))

    // Hold a stalled result
    `XSRGB_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

    `XSRGB_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))

endmodule

bind xyz_to_srgb_minmax_stretch_top xsrgb_checker u_xsrgb_checker (.*);
